@@ rtl/swerve_drive_wheel_kinematics_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the wheel kinematics checks.
// ----------------------------------------------------------------------------
`ifndef SWERVE_DRIVE_WHEEL_KINEMATICS_MACROS_SVH
`define SWERVE_DRIVE_WHEEL_KINEMATICS_MACROS_SVH

// same-cycle implication
`define SWDK_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("swdk assertion failed");

// next-cycle implication
`define SWDK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("swdk assertion failed");

`endif

@@ rtl/swdk_pkg.sv @@
// ----------------------------------------------------------------------------
// swdk_pkg
// Constants and tables for the swerve wheel kinematics pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swdk_pkg;

  localparam int unsigned GUARD_BITS = 4;
  localparam int unsigned KINV_Q24   = 10188012;
  localparam logic [31:0] RATIO_RESET = 32'd23170;

  typedef enum logic {
    REG_LENGTH_RATIO = 1'b0,
    REG_WIDTH_RATIO  = 1'b1
  } reg_idx_e;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_at(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/swdk_if.sv @@
// ----------------------------------------------------------------------------
// swdk_if
// Request channels: drive command in, wheel speeds and angles out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swdk_cmd_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] magnitude;
  logic        [W-1:0] heading;
  logic signed [W-1:0] rotation;
  modport source (output valid, magnitude, heading, rotation, input ready);
  modport sink   (input valid, magnitude, heading, rotation, output ready);
endinterface

interface swdk_wheel_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] speed_right_front;
  logic [W-1:0] speed_left_front;
  logic [W-1:0] speed_left_back;
  logic [W-1:0] speed_right_back;
  logic [W-1:0] angle_right_front;
  logic [W-1:0] angle_left_front;
  logic [W-1:0] angle_left_back;
  logic [W-1:0] angle_right_back;
  modport source (output valid, speed_right_front, speed_left_front, speed_left_back,
                  speed_right_back, angle_right_front, angle_left_front,
                  angle_left_back, angle_right_back, input ready);
  modport sink   (input valid, speed_right_front, speed_left_front, speed_left_back,
                  speed_right_back, angle_right_front, angle_left_front,
                  angle_left_back, angle_right_back, output ready);
endinterface

`default_nettype wire

@@ rtl/swerve_drive_wheel_kinematics.sv @@
// ----------------------------------------------------------------------------
// swerve_drive_wheel_kinematics
// Four-wheel swerve inverse kinematics: drive command to wheel speed/angle.
// ----------------------------------------------------------------------------
// One command is taken every cycle while no result is held at the output;
// each result passes through the rotation CORDIC, the four vectoring CORDIC
// lanes and the one-bit-per-stage speed divider (CORDIC_STAGES is capped at
// 32). The whole pipeline stalls only while a result is held at the output.
// Ratios are written over APB at 0x0 (length) and 0x4 (width).
`timescale 1ns / 1ps
`default_nettype none

module swerve_drive_wheel_kinematics #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  swdk_cmd_if.sink         cmd_i,
  swdk_wheel_if.source     wheel_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int F   = W - 1;
  localparam int NS  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int LAT = 2 * NS + 6 + W;
  localparam logic signed [32:0]  XK   = 33'sd652032768;
  localparam logic [31:0]         RND  = (32'(1) << (32 - W)) >> 1;
  localparam logic [W+1:0]        ONE  = (W+2)'(1) << F;
  localparam logic [W+32:0]       CRND = (W+33)'(1) << 29;
  localparam logic [2*W:0]        RRND = (2*W+1)'(1) << (F - 1);

  // ---------------- configuration
  logic [W-1:0] len_q, wid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= swdk_pkg::RATIO_RESET[W-1:0];
      wid_q <= swdk_pkg::RATIO_RESET[W-1:0];
    end else if (psel && penable && pwrite) begin
      case (swdk_pkg::reg_idx_e'(paddr[2]))
        swdk_pkg::REG_LENGTH_RATIO: len_q <= pwdata[W-1:0];
        swdk_pkg::REG_WIDTH_RATIO:  wid_q <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (swdk_pkg::reg_idx_e'(paddr[2]) == swdk_pkg::REG_WIDTH_RATIO) ?
                  32'(wid_q) : 32'(len_q);

  // ---------------- flow control
  logic           en;
  logic [LAT-1:0] v_q;

  assign en          = !wheel_o.valid || wheel_o.ready;
  assign cmd_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], cmd_i.valid};
    end
  end

  // ---------------- input stage and rotation CORDIC
  logic signed [32:0]  rx_q  [NS+1];
  logic signed [32:0]  ry_q  [NS+1];
  logic signed [32:0]  rz_q  [NS+1];
  logic signed [W-1:0] m_q   [NS+1];
  logic signed [2*W:0] rlp_q [NS+1];
  logic signed [2*W:0] rwp_q [NS+1];

  logic [31:0]         t, tz;
  logic                pre;
  logic signed [2*W:0] rlp, rwp;

  assign t   = (32'(cmd_i.heading) << (32 - W)) + 32'h4000_0000;
  assign pre = (t[31:30] == 2'b01) || (t[31:30] == 2'b10);
  assign tz  = pre ? t - 32'h8000_0000 : t;
  assign rlp = cmd_i.rotation * $signed({1'b0, len_q});
  assign rwp = cmd_i.rotation * $signed({1'b0, wid_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q[0]  <= pre ? -XK : XK;
      ry_q[0]  <= '0;
      rz_q[0]  <= {tz[31], tz};
      m_q[0]   <= cmd_i.magnitude;
      rlp_q[0] <= rlp;
      rwp_q[0] <= rwp;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic signed [32:0] dx, dy, at;
    assign dx = ry_q[i] >>> i;
    assign dy = rx_q[i] >>> i;
    assign at = {1'b0, swdk_pkg::atan_at(i)};
    always_ff @(posedge clk_i) begin
      if (en) begin
        m_q[i+1]   <= m_q[i];
        rlp_q[i+1] <= rlp_q[i];
        rwp_q[i+1] <= rwp_q[i];
        if (!rz_q[i][32]) begin
          rx_q[i+1] <= rx_q[i] - dx;
          ry_q[i+1] <= ry_q[i] + dy;
          rz_q[i+1] <= rz_q[i] - at;
        end else begin
          rx_q[i+1] <= rx_q[i] + dx;
          ry_q[i+1] <= ry_q[i] - dy;
          rz_q[i+1] <= rz_q[i] + at;
        end
      end
    end
  end

  // ---------------- translation and rotation terms
  logic signed [W+32:0] cxp, cyp;
  logic        [W+32:0] cxr, cyr;
  logic        [2*W:0]  rlr, rwr;
  logic signed [W:0]    cx_q, cy_q, rl_q, rw_q;

  assign cxp = m_q[NS] * rx_q[NS];
  assign cyp = m_q[NS] * ry_q[NS];
  assign cxr = cxp + CRND;
  assign cyr = cyp + CRND;
  assign rlr = rlp_q[NS] + RRND;
  assign rwr = rwp_q[NS] + RRND;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q <= cxr[W+30:30];
      cy_q <= cyr[W+30:30];
      rl_q <= rlr[F+W:F];
      rw_q <= rwr[F+W:F];
    end
  end

  logic signed [W+1:0] a_q, b_q, c_q, d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= (W+2)'(cx_q) - (W+2)'(rl_q);
      b_q <= (W+2)'(cx_q) + (W+2)'(rl_q);
      c_q <= (W+2)'(cy_q) - (W+2)'(rw_q);
      d_q <= (W+2)'(cy_q) + (W+2)'(rw_q);
    end
  end

  // ---------------- vectoring lanes: RF (C,B) LF (D,B) LB (D,A) RB (C,A)
  logic [W+1:0] mag [4];
  logic [31:0]  phi [4];

  swdk_vec_lane #(.W(W), .NS(NS)) u_lane_rf (
    .clk_i(clk_i), .en_i(en), .x_i(c_q), .y_i(b_q), .mag_o(mag[0]), .ang_o(phi[0]));
  swdk_vec_lane #(.W(W), .NS(NS)) u_lane_lf (
    .clk_i(clk_i), .en_i(en), .x_i(d_q), .y_i(b_q), .mag_o(mag[1]), .ang_o(phi[1]));
  swdk_vec_lane #(.W(W), .NS(NS)) u_lane_lb (
    .clk_i(clk_i), .en_i(en), .x_i(d_q), .y_i(a_q), .mag_o(mag[2]), .ang_o(phi[2]));
  swdk_vec_lane #(.W(W), .NS(NS)) u_lane_rb (
    .clk_i(clk_i), .en_i(en), .x_i(c_q), .y_i(a_q), .mag_o(mag[3]), .ang_o(phi[3]));

  // ---------------- largest speed and steering angles
  logic [W+1:0] mx01, mx23, mx;
  logic [W+1:0] sp_q [4];
  logic [W-1:0] ang_q [4];
  logic [W+1:0] mx_q;
  logic         norm_q;

  assign mx01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
  assign mx23 = (mag[3] > mag[2]) ? mag[3] : mag[2];
  assign mx   = (mx23 > mx01) ? mx23 : mx01;

  for (genvar j = 0; j < 4; j++) begin : g_steer
    logic [31:0] a, s;
    assign a = 32'h8000_0000 - phi[j];
    assign s = a + RND;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sp_q[j]  <= mag[j];
        ang_q[j] <= s[31:32-W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q   <= mx;
      norm_q <= mx > ONE;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage
  typedef struct packed {
    logic [W+2:0] rem;
    logic [W-1:0] q;
    logic [W-1:0] sp;
    logic [W-1:0] ang;
  } dlane_t;

  typedef struct packed {
    dlane_t [3:0] ln;
    logic [W+1:0] mx;
    logic         norm;
  } dstage_t;

  dstage_t ds_q [W];

  for (genvar k = 0; k < W; k++) begin : g_div
    dstage_t src, nxt;
    if (k == 0) begin : g_seed
      always_comb begin
        src.mx   = mx_q;
        src.norm = norm_q;
        for (int j = 0; j < 4; j++) begin
          src.ln[j].rem = {1'b0, sp_q[j]};
          src.ln[j].q   = '0;
          src.ln[j].sp  = sp_q[j][W-1:0];
          src.ln[j].ang = ang_q[j];
        end
      end
    end else begin : g_shift
      always_comb begin
        src = ds_q[k-1];
        for (int j = 0; j < 4; j++) begin
          src.ln[j].rem = ds_q[k-1].ln[j].rem << 1;
          src.ln[j].q   = ds_q[k-1].ln[j].q << 1;
        end
      end
    end
    always_comb begin
      nxt = src;
      for (int j = 0; j < 4; j++) begin
        if (src.ln[j].rem >= {1'b0, src.mx}) begin
          nxt.ln[j].q[0] = 1'b1;
          nxt.ln[j].rem  = src.ln[j].rem - {1'b0, src.mx};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        ds_q[k] <= nxt;
      end
    end
  end

  // ---------------- output
  dstage_t last;
  logic [W-1:0] spd [4];

  assign last = ds_q[W-1];
  for (genvar j = 0; j < 4; j++) begin : g_out
    assign spd[j] = last.norm ? last.ln[j].q : last.ln[j].sp;
  end

  assign wheel_o.valid             = v_q[LAT-1];
  assign wheel_o.speed_right_front = spd[0];
  assign wheel_o.speed_left_front  = spd[1];
  assign wheel_o.speed_left_back   = spd[2];
  assign wheel_o.speed_right_back  = spd[3];
  assign wheel_o.angle_right_front = last.ln[0].ang;
  assign wheel_o.angle_left_front  = last.ln[1].ang;
  assign wheel_o.angle_left_back   = last.ln[2].ang;
  assign wheel_o.angle_right_back  = last.ln[3].ang;

endmodule

`default_nettype wire

@@ rtl/swdk_vec_lane.sv @@
// ----------------------------------------------------------------------------
// swdk_vec_lane
// Pipelined CORDIC vectoring: magnitude and angle of one wheel vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swdk_vec_lane #(
  parameter int W  = 16,
  parameter int NS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic signed [W+1:0] x_i,
  input  wire logic signed [W+1:0] y_i,
  output logic             [W+1:0] mag_o,
  output logic             [31:0]  ang_o
);

  localparam int VW = W + 8;
  localparam logic signed [25:0] KS = 26'(swdk_pkg::KINV_Q24);
  localparam logic signed [VW+25:0] MRND = (VW+26)'(1) <<< 27;

  logic signed [VW-1:0] x_q [NS+1];
  logic signed [VW-1:0] y_q [NS+1];
  logic        [31:0]   z_q [NS+1];
  logic                 zero_q [NS+1];

  logic signed [VW-1:0] xe, ye;
  logic                 neg;

  assign xe  = VW'(x_i);
  assign ye  = VW'(y_i);
  assign neg = x_i[W+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      x_q[0]    <= (neg ? -xe : xe) <<< swdk_pkg::GUARD_BITS;
      y_q[0]    <= (neg ? -ye : ye) <<< swdk_pkg::GUARD_BITS;
      z_q[0]    <= neg ? 32'h8000_0000 : 32'h0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic signed [VW-1:0] dx, dy;
    logic        [31:0]   at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = swdk_pkg::atan_at(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][VW-1]) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end
      end
    end
  end

  logic signed [VW-1:0]  xc;
  logic signed [VW+25:0] prod, prodr;

  assign xc    = x_q[NS][VW-1] ? '0 : x_q[NS];
  assign prod  = xc * KS;
  assign prodr = prod + MRND;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_o <= zero_q[NS] ? '0 : prodr[W+29:28];
      ang_o <= zero_q[NS] ? 32'h0 : z_q[NS];
    end
  end

endmodule

`default_nettype wire

@@ rtl/swdk_checker.sv @@
// ----------------------------------------------------------------------------
// swdk_checker
// Port-level checks on the wheel kinematics block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "swerve_drive_wheel_kinematics_macros.svh"

module swdk_checker #(
  parameter int W = 16
) (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         cmd_ready_i,
  input wire logic         out_valid_i,
  input wire logic         out_ready_i,
  input wire logic [W-1:0] s0_i,
  input wire logic [W-1:0] s1_i,
  input wire logic [W-1:0] s2_i,
  input wire logic [W-1:0] s3_i,
  input wire logic [W-1:0] a0_i,
  input wire logic [W-1:0] a1_i,
  input wire logic [W-1:0] a2_i,
  input wire logic [W-1:0] a3_i
);

  localparam logic [W-1:0] ONE = W'(1) << (W - 1);

  // held result does not change
  `SWDK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(s0_i) && $stable(s1_i) && $stable(s2_i) && $stable(s3_i) && $stable(a0_i) && $stable(a1_i) && $stable(a2_i) && $stable(a3_i))
  // command side stalls only behind a blocked result
  `SWDK_ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, !cmd_ready_i, out_valid_i && !out_ready_i)
  // speeds are normalized to at most 1.0
  `SWDK_ASSERT_IMPLY(a_speed_range, clk_i, rst_ni, out_valid_i, s0_i <= ONE && s1_i <= ONE && s2_i <= ONE && s3_i <= ONE)

endmodule

bind swerve_drive_wheel_kinematics swdk_checker #(.W(SAMPLE_WIDTH)) u_swdk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_ready_i (cmd_i.ready),
  .out_valid_i (wheel_o.valid),
  .out_ready_i (wheel_o.ready),
  .s0_i        (wheel_o.speed_right_front),
  .s1_i        (wheel_o.speed_left_front),
  .s2_i        (wheel_o.speed_left_back),
  .s3_i        (wheel_o.speed_right_back),
  .a0_i        (wheel_o.angle_right_front),
  .a1_i        (wheel_o.angle_left_front),
  .a2_i        (wheel_o.angle_left_back),
  .a3_i        (wheel_o.angle_right_back)
);

`default_nettype wire
